@@ rtl/efcu_pkg.sv @@
// Shared types, constants and CRC function for the encoder frame checker.
`default_nettype none

package efcu_pkg;

    localparam int BYTE_W      = 8;
    localparam int ANGLE_W     = 21;
    localparam int STATUS_W    = 3;
    localparam int PAYLOAD_W   = ANGLE_W + STATUS_W;
    localparam int CRC_W       = 8;
    localparam int TURN_W      = 32;
    localparam int DELTA_W     = ANGLE_W + 2;
    localparam int IDX_W       = 3;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;

    localparam logic [IDX_W-1:0] IDX_FIRST   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_PAY_LO  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_PAY_HI  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_CRC     = 3'd5;
    localparam logic [IDX_W-1:0] IDX_IDLE    = 3'd6;

    localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(1 << (ANGLE_W - 1));
    localparam logic signed [DELTA_W-1:0] FULL_TURN = DELTA_W'(1 << ANGLE_W);

    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic [STATUS_W-1:0] status_bits;
        logic                crc_ok;
    } t_frame;

    function automatic logic [CRC_W-1:0] crc8_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb  = crc[CRC_W-1] ^ data[i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/efcu_front.sv @@
// Front end: byte framing, payload assembly and CRC check.
`default_nettype none

module efcu_front
    import efcu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_frame_start,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_frame                 o_frame
);

    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [PAYLOAD_W-1:0] r_payload, n_payload;
    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [IDX_W-1:0]     idx_eff;
    logic [CRC_W-1:0]     crc_base;
    logic                 accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign idx_eff  = i_frame_start ? IDX_FIRST : r_idx;
    assign crc_base = i_frame_start ? '0 : r_crc;

    always_comb begin
        n_idx     = r_idx;
        n_payload = r_payload;
        n_crc     = r_crc;
        o_push    = 1'b0;
        if (accept) begin
            if (i_frame_start) begin
                n_payload = '0;
                n_crc     = '0;
            end
            if (idx_eff >= IDX_PAY_LO && idx_eff <= IDX_PAY_HI) begin
                n_payload = {r_payload[PAYLOAD_W-BYTE_W-1:0], i_rx_byte};
                n_crc     = crc8_byte(crc_base, i_rx_byte);
            end
            if (idx_eff < IDX_CRC) begin
                n_idx = idx_eff + 1'b1;
            end else if (idx_eff == IDX_CRC) begin
                o_push = 1'b1;
                n_idx  = IDX_IDLE;
            end
        end
    end

    assign o_frame.angle       = r_payload[PAYLOAD_W-1:STATUS_W];
    assign o_frame.status_bits = r_payload[STATUS_W-1:0];
    assign o_frame.crc_ok      = (r_crc == i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= IDX_IDLE;
            r_payload <= '0;
            r_crc     <= '0;
        end else begin
            r_idx     <= n_idx;
            r_payload <= n_payload;
            r_crc     <= n_crc;
        end
    end

endmodule

`default_nettype wire

@@ rtl/efcu_fifo.sv @@
// Short frame queue between front and back (depth a power of two, at least 2).
`default_nettype none

module efcu_fifo
    import efcu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_data,
    output logic        o_full,
    output logic        o_empty,
    input  wire logic   i_pop,
    output t_frame      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/efcu_back.sv @@
// Back end: multi-turn unwrap and output register.
`default_nettype none

module efcu_back
    import efcu_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_empty,
    input  wire t_frame                     i_frame,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic        [ANGLE_W-1:0]       o_angle,
    output logic        [STATUS_W-1:0]      o_status_bits,
    output logic                            o_crc_ok,
    output logic signed [TURN_W-1:0]        o_position
);

    logic                       r_out_valid;
    logic [ANGLE_W-1:0]         r_angle;
    logic [STATUS_W-1:0]        r_status;
    logic                       r_crc_ok;
    logic [TURN_W-1:0]          r_position;

    logic [ANGLE_W-1:0]         r_prev_angle;
    logic [TURN_W-1:0]          r_turn;
    logic                       r_awaiting_first;

    logic signed [DELTA_W-1:0]  raw_delta;
    logic signed [DELTA_W-1:0]  delta;
    logic [TURN_W-1:0]          n_turn;

    assign o_pop = !i_q_empty && (!r_out_valid || i_ready);

    assign raw_delta = signed'({2'b00, i_frame.angle}) - signed'({2'b00, r_prev_angle});

    always_comb begin
        delta = raw_delta;
        if (raw_delta < -HALF_TURN) begin
            delta = raw_delta + FULL_TURN;
        end else if (raw_delta > HALF_TURN) begin
            delta = raw_delta - FULL_TURN;
        end
        n_turn = r_turn;
        if (i_frame.crc_ok) begin
            if (r_awaiting_first) begin
                n_turn = TURN_W'(i_frame.angle);
            end else begin
                n_turn = r_turn + {{(TURN_W-DELTA_W){delta[DELTA_W-1]}}, delta};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_prev_angle     <= '0;
            r_turn           <= '0;
            r_awaiting_first <= 1'b1;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_turn      <= n_turn;
                if (i_frame.crc_ok) begin
                    r_prev_angle     <= i_frame.angle;
                    r_awaiting_first <= 1'b0;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_angle    <= i_frame.angle;
            r_status   <= i_frame.status_bits;
            r_crc_ok   <= i_frame.crc_ok;
            r_position <= n_turn;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_angle       = r_angle;
    assign o_status_bits = r_status;
    assign o_crc_ok      = r_crc_ok;
    assign o_position    = signed'(r_position);

endmodule

`default_nettype wire

@@ rtl/encoder_frame_check_unwrap.sv @@
// Top level: angle-sensor frame checker with multi-turn unwrap.
//
// Input channel (i_valid / o_ready) takes one received byte per item,
// i_rx_byte, with i_frame_start high on the first byte of a six-byte frame.
// A start byte aborts any partial frame. Bytes outside a frame are dropped.
// Bytes 2..4 carry a 21-bit angle and 3 status bits; byte 5 is a CRC-8
// (poly 0x07, zero init, MSB first) over those bytes.
// Output channel (o_valid / i_ready) gives one item per frame: angle,
// status, CRC flag and the 32-bit multi-turn position. Frames with a bad
// CRC leave the position as it was; the first good frame seeds it.
// Throughput: one byte per cycle while o_ready is high; the CRC byte update
// in the front end and the delta add in the back end are combinational.
// A frame enters the queue when its final byte is accepted; the back end
// then pops it into the o_valid output register once that register is free.
// A frame queue of QUEUE_DEPTH entries sits between front and back; when
// the receiver stalls, results fill the output register and the queue, and
// then o_ready drops until the receiver takes an item.
// Reset (synchronous, active low) empties the queue, returns the framer to
// idle and clears the position so the next good frame seeds it again.
`default_nettype none

module encoder_frame_check_unwrap
    import efcu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [BYTE_W-1:0]     i_rx_byte,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ANGLE_W-1:0]         o_angle,
    output logic [STATUS_W-1:0]        o_status_bits,
    output logic                       o_crc_ok,
    output logic signed [TURN_W-1:0]   o_position
);

    t_frame front_frame;
    t_frame queue_frame;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    efcu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_frame       (front_frame)
    );

    efcu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_frame),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (pop),
        .o_data  (queue_frame)
    );

    efcu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_frame       (queue_frame),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_angle       (o_angle),
        .o_status_bits (o_status_bits),
        .o_crc_ok      (o_crc_ok),
        .o_position    (o_position)
    );

endmodule

`default_nettype wire
